[rtl/core/tbs_pkg.sv]
// tbs_pkg: shared types, constants and codes of the token bucket packet shaper.
// No dependencies; used by tbs_front, tbs_back and the top level.
package tbs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int CMDQ_DEPTH      = 2;
	localparam int RESQ_DEPTH      = 4;

	localparam int COST_W   = 16;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 2;
	localparam int RATE_W   = 24;
	localparam int LIMIT_W  = 20;
	localparam int CREDIT_W = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};

	// floor(x/100) = floor((x>>2)/25); reciprocal of 25 scaled by 2^30, exact below 2^30
	localparam int QUARTER_W   = CREDIT_W - 2;
	localparam int RECIP_W     = 26;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_25 = 26'd42949673;

	// input operation codes
	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHAPING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_RELEASED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVER_LIMIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FIFO_FULL  = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  tag;
	} in_item_t;

	typedef struct packed {
		logic [TAG_W-1:0]    packet_tag;
		logic [STATUS_W-1:0] status;
		logic                last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_PASS,
		CMD_ENQ
	} cmd_kind_e;

	typedef struct packed {
		cmd_kind_e         kind;
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  tag;
	} cmd_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// configuration-derived values handed from front to back
	typedef struct packed {
		logic [CREDIT_W-1:0] bucket;
		logic [CREDIT_W-1:0] tick_add;
		logic                clamp;
		logic [LIMIT_W-1:0]  limit;
	} shp_cfg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_FLUSH
	} back_state_e;

endpackage

[rtl/core/tbs_ram.sv]
// tbs_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/tbs_fifo.sv]
// tbs_fifo: small generic register queue with push/full and pop/empty sides.
// No dependencies; used for the command queue and the result queue.
module tbs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/tbs_front.sv]
// tbs_front: configuration registers, bucket size and tick increment, item classification.
// Depends on tbs_pkg.
module tbs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            push,
	input  tbs_pkg::in_item_t               item,
	output logic                            cmd_push,
	output tbs_pkg::cmd_t                   cmd,
	output tbs_pkg::shp_cfg_t               cfg
);

	localparam int R25_W = tbs_pkg::RATE_W + 5;
	localparam int PROD_W = tbs_pkg::QUARTER_W + tbs_pkg::RECIP_W;

	logic                             shaping_q;
	logic [tbs_pkg::CREDIT_W-1:0]     bucket_q;
	logic [tbs_pkg::CREDIT_W-1:0]     add_q;
	logic [tbs_pkg::LIMIT_W-1:0]      limit_q;
	logic                             clamp_q;
	logic                             cfg_wr;
	logic [tbs_pkg::RATE_W-1:0]       rate;
	logic [R25_W-1:0]                 rate25;
	logic [R25_W-2:0]                 half;
	logic [tbs_pkg::CREDIT_W-1:0]     bucket_new;
	logic [tbs_pkg::QUARTER_W-1:0]    quarter;
	logic [PROD_W-1:0]                prod;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// rate*25/2, saturated to the credit width
	assign rate   = cfg_data[tbs_pkg::RATE_W-1:0];
	assign rate25 = R25_W'({rate, 4'b0}) + R25_W'({rate, 3'b0}) + R25_W'(rate);
	assign half   = rate25[R25_W-1:1];
	assign bucket_new = (half > (R25_W-1)'(tbs_pkg::CREDIT_MAX)) ? tbs_pkg::CREDIT_MAX
		: half[tbs_pkg::CREDIT_W-1:0];

	// bucket/100 by reciprocal multiply
	assign quarter = bucket_q[tbs_pkg::CREDIT_W-1:2];
	assign prod    = PROD_W'(quarter) * PROD_W'(tbs_pkg::RECIP_25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shaping_q <= 1'b0;
			bucket_q  <= '0;
			add_q     <= '0;
			limit_q   <= '0;
			clamp_q   <= 1'b0;
		end else begin
			clamp_q <= 1'b0;
			add_q   <= tbs_pkg::CREDIT_W'(prod[PROD_W-1:tbs_pkg::RECIP_SHIFT]);
			if (cfg_wr) begin
				case (cfg_index)
					tbs_pkg::CFG_SHAPING: begin
						shaping_q <= cfg_data[0];
					end
					tbs_pkg::CFG_RATE: begin
						bucket_q <= bucket_new;
						clamp_q  <= 1'b1;
					end
					tbs_pkg::CFG_LIMIT: begin
						limit_q <= cfg_data[tbs_pkg::LIMIT_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cmd_push = push;
	assign cmd.cost = item.cost;
	assign cmd.tag  = item.tag;
	assign cmd.kind = (item.operation == tbs_pkg::OP_TICK) ? tbs_pkg::CMD_TICK
		: (shaping_q ? tbs_pkg::CMD_ENQ : tbs_pkg::CMD_PASS);

	assign cfg.bucket   = bucket_q;
	assign cfg.tick_add = add_q;
	assign cfg.clamp    = clamp_q;
	assign cfg.limit    = limit_q;

endmodule

[rtl/core/tbs_back.sv]
// tbs_back: shaping sequencer with credit, packet queue storage and release logic.
// Depends on tbs_pkg and tbs_ram.
module tbs_back #(
	parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tbs_pkg::shp_cfg_t   cfg,
	input  tbs_pkg::cmd_t       cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output tbs_pkg::out_item_t  res_item
);

	localparam int HW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int QB_W = HW + tbs_pkg::COST_W;
	localparam int CMP_W = (QB_W > tbs_pkg::LIMIT_W) ? QB_W : tbs_pkg::LIMIT_W;
	localparam int NR_W = $clog2(tbs_pkg::MAX_RESULTS + 1);
	localparam int EW   = $bits(tbs_pkg::entry_t);

	tbs_pkg::back_state_e          state_q, state_d;
	logic [tbs_pkg::CREDIT_W-1:0]  credit_q;
	logic [QB_W-1:0]               queued_q;
	logic [HW-1:0]                 head_q;
	logic [CW-1:0]                 count_q;
	logic [NR_W-1:0]               nrel_q;
	logic                          pend_v_q;
	logic [tbs_pkg::TAG_W-1:0]     pend_tag_q;
	logic [tbs_pkg::STATUS_W-1:0]  pend_status_q;

	logic [HW:0]                   tail_sum;
	logic [HW-1:0]                 tail;
	logic [HW-1:0]                 head_nxt;
	logic                          ram_we;
	logic [EW-1:0]                 ram_rdata;
	tbs_pkg::entry_t               ram_wentry;
	tbs_pkg::entry_t               head_ent;
	logic                          over_limit;
	logic                          q_full;
	logic                          drain_stop;
	logic                          eligible;
	logic                          release_now;
	logic                          credit_upd;
	logic [tbs_pkg::CREDIT_W:0]    tick_sum;
	logic [tbs_pkg::CREDIT_W-1:0]  tick_credit;
	logic [tbs_pkg::CREDIT_W-1:0]  head_cost;

	assign tail_sum = {1'b0, head_q} + (HW+1)'(count_q);
	assign tail     = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
		? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : tail_sum[HW-1:0];
	assign head_nxt = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign ram_wentry.cost = cmd.cost;
	assign ram_wentry.tag  = cmd.tag;
	assign head_ent  = ram_rdata;
	assign head_cost = tbs_pkg::CREDIT_W'(head_ent.cost);

	tbs_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail),
		.wdata (ram_wentry),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	assign over_limit = (cfg.limit != '0) && (CMP_W'(queued_q) > CMP_W'(cfg.limit));
	assign q_full     = (count_q == CW'(QUEUE_DEPTH));
	assign drain_stop = (count_q == '0) || (nrel_q == NR_W'(tbs_pkg::MAX_RESULTS));
	assign eligible   = (credit_q >= head_cost);

	assign tick_sum    = {1'b0, credit_q} + {1'b0, cfg.tick_add};
	assign tick_credit = (tick_sum > {1'b0, cfg.bucket}) ? cfg.bucket
		: tick_sum[tbs_pkg::CREDIT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tbs_pkg::S_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						tbs_pkg::CMD_TICK: state_d = tbs_pkg::S_READ;
						tbs_pkg::CMD_PASS: state_d = tbs_pkg::S_FLUSH;
						tbs_pkg::CMD_ENQ: begin
							state_d = (over_limit || q_full) ? tbs_pkg::S_FLUSH
								: tbs_pkg::S_READ;
						end
						default: state_d = tbs_pkg::S_IDLE;
					endcase
				end
			end
			tbs_pkg::S_READ: begin
				if (drain_stop) begin
					state_d = pend_v_q ? tbs_pkg::S_FLUSH : tbs_pkg::S_IDLE;
				end else begin
					state_d = tbs_pkg::S_CHECK;
				end
			end
			tbs_pkg::S_CHECK: begin
				if (eligible) begin
					if (!(pend_v_q && res_full)) begin
						state_d = tbs_pkg::S_READ;
					end
				end else begin
					state_d = pend_v_q ? tbs_pkg::S_FLUSH : tbs_pkg::S_IDLE;
				end
			end
			tbs_pkg::S_FLUSH: begin
				if (!res_full) begin
					state_d = tbs_pkg::S_IDLE;
				end
			end
			default: state_d = tbs_pkg::S_IDLE;
		endcase
	end

	// outputs and datapath strobes
	always_comb begin
		cmd_pop     = (state_q == tbs_pkg::S_IDLE) && !cmd_empty;
		ram_we      = cmd_pop && (cmd.kind == tbs_pkg::CMD_ENQ) && !over_limit && !q_full;
		release_now = (state_q == tbs_pkg::S_CHECK) && eligible && !(pend_v_q && res_full);
		credit_upd  = (cmd_pop && (cmd.kind == tbs_pkg::CMD_TICK)) || release_now;
		res_push    = ((state_q == tbs_pkg::S_CHECK) && eligible && pend_v_q && !res_full)
			|| ((state_q == tbs_pkg::S_FLUSH) && !res_full);
		res_item.packet_tag = pend_tag_q;
		res_item.status     = pend_status_q;
		res_item.last       = (state_q == tbs_pkg::S_FLUSH);
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pend_tag_q <= cmd.tag;
			if (cmd.kind == tbs_pkg::CMD_ENQ && over_limit) begin
				pend_status_q <= tbs_pkg::ST_OVER_LIMIT;
			end else if (cmd.kind == tbs_pkg::CMD_ENQ) begin
				pend_status_q <= tbs_pkg::ST_FIFO_FULL;
			end else begin
				pend_status_q <= tbs_pkg::ST_RELEASED;
			end
		end else if (release_now) begin
			pend_tag_q    <= head_ent.tag;
			pend_status_q <= tbs_pkg::ST_RELEASED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tbs_pkg::S_IDLE;
			credit_q <= '0;
			queued_q <= '0;
			head_q   <= '0;
			count_q  <= '0;
			nrel_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// skipped when a tick or a release updates the credit; a tick saturates at the bucket anyway
			if (cfg.clamp && !credit_upd && (credit_q > cfg.bucket)) begin
				credit_q <= cfg.bucket;
			end
			if (cmd_pop) begin
				nrel_q <= '0;
				case (cmd.kind)
					tbs_pkg::CMD_TICK: credit_q <= tick_credit;
					tbs_pkg::CMD_PASS: pend_v_q <= 1'b1;
					tbs_pkg::CMD_ENQ: begin
						if (over_limit || q_full) begin
							pend_v_q <= 1'b1;
						end else begin
							count_q  <= count_q + 1'b1;
							queued_q <= queued_q + QB_W'(cmd.cost);
						end
					end
					default: begin
					end
				endcase
			end else if (release_now) begin
				credit_q <= credit_q - head_cost;
				queued_q <= queued_q - QB_W'(head_ent.cost);
				head_q   <= head_nxt;
				count_q  <= count_q - 1'b1;
				nrel_q   <= nrel_q + 1'b1;
				pend_v_q <= 1'b1;
			end else if (state_q == tbs_pkg::S_FLUSH && !res_full) begin
				pend_v_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/token_bucket_packet_shaper.sv]
// Token bucket packet shaper with a queue of packets awaiting credit.
// With shaping off, or when a packet is dropped, an item goes through the back-end
// sequencer's decode and result steps. A tick or a queued packet is decoded, then
// each release needs a read of the packet store, which has a registered read port,
// and a compare against the credit; the head packet may be checked and left waiting
// for credit, and the last result is handed over when any packet leaves. A full
// result queue stalls the sequencer. At most 16 packets leave per input item; the
// rest wait for a later tick or queued packet. Results go to a small output queue,
// so input keeps flowing while results wait to be popped. Configuration writes are
// registered; a rate write resizes the bucket and trims the credit to it on the
// following cycle unless a release updates the credit in that cycle.
// Depends on tbs_pkg, tbs_front, tbs_fifo, tbs_back and tbs_ram.
module token_bucket_packet_shaper #(
	parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input items: packet arrivals and 1 ms ticks
	input  logic                            push,
	output logic                            full,
	input  tbs_pkg::in_item_t               item,
	// result items: released or dropped packets
	output logic                            empty,
	input  logic                            pop,
	output tbs_pkg::out_item_t              result
);

	localparam int CMD_W = $bits(tbs_pkg::cmd_t);
	localparam int RES_W = $bits(tbs_pkg::out_item_t);

	tbs_pkg::shp_cfg_t   cfg;
	tbs_pkg::cmd_t       cmd_in;
	tbs_pkg::cmd_t       cmd_out;
	tbs_pkg::out_item_t  res_in;
	logic                cmd_push;
	logic                cmd_empty;
	logic                cmd_pop;
	logic                res_push;
	logic                res_full;
	logic [CMD_W-1:0]    cmd_rdata;
	logic [RES_W-1:0]    res_rdata;

	// front: config registers and item classification (tick / pass / enqueue)
	tbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cfg       (cfg)
	);

	// command queue decouples acceptance from execution; its full is the block's full
	tbs_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (tbs_pkg::CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign cmd_out = cmd_rdata;

	// back: credit, packet store and release sequencing
	tbs_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_in)
	);

	// result queue toward the consumer
	tbs_fifo #(
		.WIDTH (RES_W),
		.DEPTH (tbs_pkg::RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign result = res_rdata;

endmodule
